### sv/i2cbm_pkg.sv
// Shared types and constants of the I2C bit-level master.
package i2cbm_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd250;
  localparam logic [BitCntW-1:0]  BitsPerByte  = 4'd8;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WAIT  = 3'd5
  } op_e;

  typedef enum logic [5:0] {
    CMD_IDLE  = 6'b000001,
    CMD_START = 6'b000010,
    CMD_STOP  = 6'b000100,
    CMD_WRITE = 6'b001000,
    CMD_READ  = 6'b010000,
    CMD_WAIT  = 6'b100000
  } cmd_state_e;

  typedef struct packed {
    logic             ack_failed;
    logic [ByteW-1:0] rd_data;
    logic             done_res;
    logic             busy_res;
    logic             sda_level;
    logic             scl_level;
  } i2cbm_res_t;

endpackage

### sv/i2cbm_seq.sv
// Command sequencer of the I2C bit-level master: state registers and one-tick step logic.
module i2cbm_seq
  import i2cbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [OpW-1:0]      op_i,
  input  logic [ByteW-1:0]    wr_data_i,
  input  logic                send_ack_i,
  input  logic                sda_in_i,
  input  logic [TimeoutW-1:0] ack_timeout_i,
  output i2cbm_res_t          res_o
);

  cmd_state_e          cmd_q, cmd_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [TimeoutW-1:0] wait_cnt_q, wait_cnt_d;
  logic                ack_choice_q, ack_choice_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                fail_q, fail_d;
  logic [ByteW-1:0]    rd_q, rd_d;
  logic                done;
  logic [BitCntW-1:0]  bit_inc;

  always_comb begin
    cmd_d        = cmd_q;
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    wait_cnt_d   = wait_cnt_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    fail_d       = fail_q;
    rd_d         = rd_q;
    done         = 1'b0;

    if (cmd_q == CMD_IDLE) begin
      unique case (op_i)
        OP_START: cmd_d = CMD_START;
        OP_STOP:  cmd_d = CMD_STOP;
        OP_WRITE: cmd_d = CMD_WRITE;
        OP_READ:  cmd_d = CMD_READ;
        OP_WAIT:  cmd_d = CMD_WAIT;
        default:  cmd_d = CMD_IDLE;
      endcase
      if (cmd_d != CMD_IDLE) begin
        phase_d   = '0;
        bit_cnt_d = '0;
      end
      if (cmd_d == CMD_WRITE) begin
        shift_d = wr_data_i;
      end
      if (cmd_d == CMD_READ) begin
        shift_d      = '0;
        ack_choice_d = send_ack_i;
      end
    end

    bit_inc = bit_cnt_d + 4'd1;

    unique case (cmd_d)
      CMD_START: begin
        if (phase_d == 3'd0) begin
          sda_d = 1'b1; scl_d = 1'b1; phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          sda_d = 1'b0; phase_d = 3'd2;
        end else begin
          scl_d = 1'b0; done = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase_d == 3'd0) begin
          scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          scl_d = 1'b1; phase_d = 3'd2;
        end else begin
          sda_d = 1'b1; done = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase_d == 3'd0) begin
          scl_d   = 1'b0;
          sda_d   = shift_d[ByteW-1];
          shift_d = {shift_d[ByteW-2:0], 1'b0};
          phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          scl_d = 1'b1; phase_d = 3'd2;
        end else begin
          scl_d     = 1'b0;
          bit_cnt_d = bit_inc;
          if (bit_inc >= BitsPerByte) begin
            done = 1'b1;
          end else begin
            phase_d = 3'd0;
          end
        end
      end
      CMD_READ: begin
        unique case (phase_d)
          3'd0: begin
            scl_d = 1'b0; sda_d = 1'b1; phase_d = 3'd1;
          end
          3'd1: begin
            scl_d     = 1'b1;
            shift_d   = {shift_d[ByteW-2:0], sda_in_i};
            bit_cnt_d = bit_inc;
            phase_d   = (bit_inc >= BitsPerByte) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            scl_d = 1'b0; sda_d = ~ack_choice_d; phase_d = 3'd3;
          end
          3'd3: begin
            scl_d = 1'b1; phase_d = 3'd4;
          end
          default: begin
            scl_d = 1'b0; rd_d = shift_d; done = 1'b1;
          end
        endcase
      end
      CMD_WAIT: begin
        unique case (phase_d)
          3'd0: begin
            sda_d = 1'b1; wait_cnt_d = '0; phase_d = 3'd1;
          end
          3'd1: begin
            scl_d = 1'b1; phase_d = 3'd2;
          end
          3'd2: begin
            if (!sda_in_i) begin
              scl_d = 1'b0; fail_d = 1'b0; done = 1'b1;
            end else if (wait_cnt_d >= ack_timeout_i) begin
              scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd3;
            end else begin
              wait_cnt_d = wait_cnt_d + 16'd1;
            end
          end
          3'd3: begin
            scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd4;
          end
          3'd4: begin
            scl_d = 1'b1; phase_d = 3'd5;
          end
          default: begin
            sda_d = 1'b1; fail_d = 1'b1; done = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    if (done) begin
      cmd_d   = CMD_IDLE;
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= CMD_IDLE;
      phase_q      <= '0;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      wait_cnt_q   <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      fail_q       <= 1'b0;
      rd_q         <= '0;
    end else if (step_i) begin
      cmd_q        <= cmd_d;
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      wait_cnt_q   <= wait_cnt_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      fail_q       <= fail_d;
      rd_q         <= rd_d;
    end
  end

  assign res_o.scl_level  = scl_d;
  assign res_o.sda_level  = sda_d;
  assign res_o.busy_res   = (cmd_d != CMD_IDLE);
  assign res_o.done_res   = done;
  assign res_o.rd_data    = rd_d;
  assign res_o.ack_failed = fail_d;

`ifndef NO_ASSERTIONS
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> cmd_q == CMD_IDLE)
    else $error("sequencer not idle after a finished command");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= 3'd5)
    else $error("phase out of range");
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= BitsPerByte)
    else $error("bit count beyond one byte");
  a_idle_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_IDLE |-> phase_q == 3'd0)
    else $error("idle sequencer with non-zero phase");
`endif

endmodule

### sv/i2c_bit_level_master_unit.sv
// Top level of the I2C bit-level master: input register, sequencer, result register.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tick word: tdata, op in tuser
//  m_axis    out  m_axis_tvalid/m_axis_tready  result word: tdata
//  cfg       in   cfg_valid_i/cfg_ready_o      ack_timeout (16 bits)
//
// Every accepted word yields exactly one result word. A word is captured in the
// input register, then moves through the sequencer step into the result
// register, so one word per cycle is sustained while the result side does not stall.
// Reset returns the sequencer to idle with both lines released and the timeout
// to 250 ticks. A stalled result holds the input register; the input side
// takes a new word whenever that register is empty or moving on.
module i2c_bit_level_master_unit
  import i2cbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] wr_data, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  // [11:4] rd_data, [12] ack_failed, [15:13] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimeoutW-1:0] cfg_data_i
);

  logic                in_valid_q;
  logic [OpW-1:0]      op_q;
  logic [ByteW-1:0]    wr_data_q;
  logic                send_ack_q;
  logic                sda_in_q;
  logic                out_valid_q;
  i2cbm_res_t          out_q;
  logic [TimeoutW-1:0] timeout_q;
  logic                adv;
  logic                in_take;
  i2cbm_res_t          res;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q       <= s_axis_tuser;
      wr_data_q  <= s_axis_tdata[ByteW-1:0];
      send_ack_q <= s_axis_tdata[ByteW];
      sda_in_q   <= s_axis_tdata[ByteW+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  i2cbm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .op_i          (op_q),
    .wr_data_i     (wr_data_q),
    .send_ack_i    (send_ack_q),
    .sda_in_i      (sda_in_q),
    .ack_timeout_i (timeout_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(i2cbm_res_t)){1'b0}}, out_q};

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !adv)
    else $error("stalled result word overwritten");
  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("stepped word did not reach the result register");
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(op_q) && $stable(wr_data_q))
    else $error("held input word lost or changed");
`endif

endmodule

### test/i2c_bit_level_master_unit_tb.sv
// Self-checking testbench for the I2C bit-level master: directed table, then random bus transfers.
module i2c_bit_level_master_unit_tb;
  import i2cbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;
  localparam int unsigned NeverAck = 1_000_000;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] wr;
    logic             ack;
    logic             sda;
    logic [15:0]      reps;
    logic             typed;
    i2cbm_res_t       res;
  } plan_row_t;

  // Result words are written fail, rd_data, done, busy, sda, scl.
  localparam plan_row_t Plan [24] = '{
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd1,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OpSpare6, 8'hFF, 1'b1, 1'b1, 16'd1,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OpSpare7, 8'h00, 1'b0, 1'b0, 16'd1,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_START, 8'h00, 1'b0, 1'b1, 16'd1,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd2,   1'b0, '0},
    '{OP_WRITE, 8'hFF, 1'b1, 1'b1, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd23,  1'b0, '0},
    '{OP_WRITE, 8'hA5, 1'b0, 1'b0, 16'd1,   1'b0, '0},
    '{OP_STOP,  8'h5A, 1'b1, 1'b1, 16'd23,  1'b0, '0},
    '{OP_READ,  8'h00, 1'b1, 1'b1, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b1, 16'd18,  1'b0, '0},
    '{OP_READ,  8'hFF, 1'b0, 1'b0, 16'd1,   1'b0, '0},
    '{OP_WAIT,  8'hFF, 1'b1, 1'b0, 16'd18,  1'b0, '0},
    '{OP_WAIT,  8'h00, 1'b0, 1'b0, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd2,   1'b0, '0},
    '{OP_WAIT,  8'h00, 1'b0, 1'b1, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b1, 16'd262, 1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b1, 16'd1,   1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_STOP,  8'h00, 1'b0, 1'b0, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd2,   1'b0, '0},
    '{OP_WAIT,  8'h00, 1'b0, 1'b1, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b1, 16'd5,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd1,   1'b0, '0},
    '{OP_TICK,  8'h00, 1'b0, 1'b0, 16'd1,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TimeoutW-1:0] cfg_data_i;

  op_e                 seq_cmd = OP_TICK;
  logic [PhaseW-1:0]   seq_phase = '0;
  logic [BitCntW-1:0]  bits_done = '0;
  logic [ByteW-1:0]    shifter = '0;
  logic [ByteW-1:0]    rd_byte = '0;
  logic [TimeoutW-1:0] wait_cnt = '0;
  logic [TimeoutW-1:0] bus_timeout = TimeoutReset;
  logic                ack_low = 1'b0;
  logic                scl_drv = 1'b1;
  logic                sda_drv = 1'b1;
  logic                ack_fail = 1'b0;

  i2cbm_res_t          line_q [$];
  i2cbm_res_t          got_res;
  i2cbm_res_t          want_res;
  int                  fails = 0;
  int unsigned         send_gap_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         words_sent = 0;

  i2c_bit_level_master_unit DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("i2c_bit_level_master_unit_tb: done, errors");
    $finish;
  end

  function automatic logic stop_step(input logic [PhaseW-1:0] base);
    if (seq_phase == base) begin
      scl_drv = 1'b0;
      sda_drv = 1'b0;
      seq_phase = base + 1'b1;
      return 1'b0;
    end
    if (seq_phase == base + 1'b1) begin
      scl_drv = 1'b1;
      seq_phase = base + 2'd2;
      return 1'b0;
    end
    sda_drv = 1'b1;
    return 1'b1;
  endfunction

  function automatic i2cbm_res_t bus_step(input logic [OpW-1:0] op, input logic [ByteW-1:0] wr,
                                          input logic ack, input logic sda);
    i2cbm_res_t r;
    logic       fin;
    fin = 1'b0;
    if (seq_cmd == OP_TICK && op >= OP_START && op <= OP_WAIT) begin
      seq_cmd = op_e'(op);
      seq_phase = '0;
      bits_done = '0;
      if (op == OP_WRITE) shifter = wr;
      if (op == OP_READ) begin
        shifter = '0;
        ack_low = ack;
      end
    end
    case (seq_cmd)
      OP_START: begin
        case (seq_phase)
          3'd0: begin
            sda_drv = 1'b1;
            scl_drv = 1'b1;
            seq_phase = 3'd1;
          end
          3'd1: begin
            sda_drv = 1'b0;
            seq_phase = 3'd2;
          end
          default: begin
            scl_drv = 1'b0;
            fin = 1'b1;
          end
        endcase
      end
      OP_STOP: fin = stop_step(3'd0);
      OP_WRITE: begin
        case (seq_phase)
          3'd0: begin
            scl_drv = 1'b0;
            sda_drv = shifter[7];
            shifter = {shifter[6:0], 1'b0};
            seq_phase = 3'd1;
          end
          3'd1: begin
            scl_drv = 1'b1;
            seq_phase = 3'd2;
          end
          default: begin
            scl_drv = 1'b0;
            bits_done = bits_done + 1'b1;
            if (bits_done >= BitsPerByte) fin = 1'b1;
            else seq_phase = 3'd0;
          end
        endcase
      end
      OP_READ: begin
        case (seq_phase)
          3'd0: begin
            scl_drv = 1'b0;
            sda_drv = 1'b1;
            seq_phase = 3'd1;
          end
          3'd1: begin
            scl_drv = 1'b1;
            shifter = {shifter[6:0], sda};
            bits_done = bits_done + 1'b1;
            seq_phase = (bits_done >= BitsPerByte) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            scl_drv = 1'b0;
            sda_drv = ~ack_low;
            seq_phase = 3'd3;
          end
          3'd3: begin
            scl_drv = 1'b1;
            seq_phase = 3'd4;
          end
          default: begin
            scl_drv = 1'b0;
            rd_byte = shifter;
            fin = 1'b1;
          end
        endcase
      end
      OP_WAIT: begin
        case (seq_phase)
          3'd0: begin
            sda_drv = 1'b1;
            wait_cnt = '0;
            seq_phase = 3'd1;
          end
          3'd1: begin
            scl_drv = 1'b1;
            seq_phase = 3'd2;
          end
          3'd2: begin
            if (!sda) begin
              scl_drv = 1'b0;
              ack_fail = 1'b0;
              fin = 1'b1;
            end else if (wait_cnt >= bus_timeout) begin
              scl_drv = 1'b0;
              sda_drv = 1'b0;
              seq_phase = 3'd3;
            end else begin
              wait_cnt = wait_cnt + 1'b1;
            end
          end
          default: begin
            if (stop_step(3'd3)) begin
              ack_fail = 1'b1;
              fin = 1'b1;
            end
          end
        endcase
      end
      default: ;
    endcase
    if (fin) begin
      seq_cmd = OP_TICK;
      seq_phase = '0;
    end
    r.scl_level = scl_drv;
    r.sda_level = sda_drv;
    r.busy_res = (seq_cmd != OP_TICK);
    r.done_res = fin;
    r.rd_data = rd_byte;
    r.ack_failed = ack_fail;
    return r;
  endfunction

  task automatic put_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] wr,
                          input logic ack, input logic sda,
                          input logic typed, input i2cbm_res_t res);
    int unsigned gap;
    i2cbm_res_t  pred;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser <= op;
    s_axis_tdata <= {6'b0, sda, ack, wr};
    s_axis_tvalid <= 1'b1;
    pred = bus_step(op, wr, ack, sda);
    line_q.push_back(typed ? res : pred);
    words_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic run_command(input logic [OpW-1:0] op, input bit long_nack);
    int unsigned ack_at;
    int unsigned n;
    logic [OpW-1:0] extra_op;
    if (long_nack || (bus_timeout <= 40 && $urandom_range(3) == 0)) ack_at = NeverAck;
    else ack_at = $urandom_range(0, (bus_timeout <= 20) ? bus_timeout + 2 : 20);
    put_item(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    n = 1;
    while (seq_cmd != OP_TICK) begin
      extra_op = ($urandom_range(5) == 0) ? 3'($urandom_range(7)) : OP_TICK;
      put_item(extra_op, 8'($urandom), 1'($urandom),
               (op == OP_WAIT) ? (n < ack_at + 2) : 1'($urandom), 1'b0, '0);
      n++;
    end
  endtask

  task automatic bus_transfer(input bit long_nack);
    int unsigned k;
    if ($urandom_range(4) == 0) begin
      run_command(3'($urandom_range(7)), 1'b0);
    end else begin
      run_command(OP_START, 1'b0);
      run_command(OP_WRITE, 1'b0);
      run_command(OP_WAIT, long_nack);
      k = $urandom_range(1);
      repeat (k) begin
        if ($urandom_range(1) == 0) begin
          run_command(OP_WRITE, 1'b0);
          run_command(OP_WAIT, 1'b0);
        end else begin
          run_command(OP_READ, 1'b0);
        end
      end
      if ($urandom_range(7) != 0) run_command(OP_STOP, 1'b0);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [TimeoutW-1:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bus_timeout = value;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = i2cbm_res_t'(m_axis_tdata[$bits(i2cbm_res_t)-1:0]);
      if (line_q.size() == 0) begin
        $error("result word arrived with nothing expected");
        fails++;
      end else begin
        want_res = line_q.pop_front();
        if (got_res.scl_level !== want_res.scl_level) begin
          $error("scl_level: expected %0d, got %0d", want_res.scl_level, got_res.scl_level);
          fails++;
        end
        if (got_res.sda_level !== want_res.sda_level) begin
          $error("sda_level: expected %0d, got %0d", want_res.sda_level, got_res.sda_level);
          fails++;
        end
        if (got_res.busy_res !== want_res.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want_res.busy_res, got_res.busy_res);
          fails++;
        end
        if (got_res.done_res !== want_res.done_res) begin
          $error("done_res: expected %0d, got %0d", want_res.done_res, got_res.done_res);
          fails++;
        end
        if (got_res.rd_data !== want_res.rd_data) begin
          $error("rd_data: expected 0x%02h, got 0x%02h", want_res.rd_data, got_res.rd_data);
          fails++;
        end
        if (got_res.ack_failed !== want_res.ack_failed) begin
          $error("ack_failed: expected %0d, got %0d", want_res.ack_failed, got_res.ack_failed);
          fails++;
        end
      end
    end
  end

  initial begin
    int unsigned      phase_base;
    logic [TimeoutW-1:0] timeouts [6];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_TICK;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    timeouts = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 40)), TimeoutReset,
                 16'($urandom_range(41, 65535))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) begin
      repeat (Plan[i].reps) begin
        put_item(Plan[i].op, Plan[i].wr, Plan[i].ack, Plan[i].sda, Plan[i].typed, Plan[i].res);
      end
    end

    // Zero timeout phase: a full first transfer has an ack wait that never sees SDA low.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      set_timeout(timeouts[ph]);
      send_gap_pct = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 36 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 36 : 0;
      phase_base = words_sent;
      bus_transfer(ph == 1);
      while (words_sent - phase_base < 30) bus_transfer(1'b0);
    end

    settle();
    if (fails == 0) begin
      $display("i2c_bit_level_master_unit_tb: done, clean");
    end else begin
      $display("i2c_bit_level_master_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
